// File: design/ookpwm_pkg.sv
// ----------------------------------------------------------------------------
// ookpwm_pkg
// Types and constants shared by the OOK pulse-width code transmitter.
// ----------------------------------------------------------------------------
package ookpwm_pkg;

    typedef struct packed {
        logic        operation;
        logic [23:0] code;
    } t_in;

    typedef struct packed {
        logic data_level;
        logic tx_power;
        logic busy_res;
        logic finished;
        logic start_ignored;
    } t_out;

    typedef struct packed {
        logic [11:0] short_ticks;
        logic [11:0] long_ticks;
        logic [15:0] gap_ticks;
        logic [3:0]  repeat_count;
    } t_cfg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_GAP  = 2'd3;

    localparam int          ADDR_W       = 4;
    localparam logic [1:0]  REG_SHORT    = 2'd0;
    localparam logic [1:0]  REG_LONG     = 2'd1;
    localparam logic [1:0]  REG_GAP      = 2'd2;
    localparam logic [1:0]  REG_REPEAT   = 2'd3;

    localparam logic [11:0] RST_SHORT    = 12'd55;
    localparam logic [11:0] RST_LONG     = 12'd165;
    localparam logic [15:0] RST_GAP      = 16'd1595;
    localparam logic [3:0]  RST_REPEAT   = 4'd7;

endpackage

// File: design/ookpwm_regs.sv
// ----------------------------------------------------------------------------
// ookpwm_regs
// APB-style configuration registers: pulse timing and packet repeat count.
// ----------------------------------------------------------------------------
module ookpwm_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ookpwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output ookpwm_pkg::t_cfg               o_cfg
);

    ookpwm_pkg::t_cfg r_cfg;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks  <= ookpwm_pkg::RST_SHORT;
            r_cfg.long_ticks   <= ookpwm_pkg::RST_LONG;
            r_cfg.gap_ticks    <= ookpwm_pkg::RST_GAP;
            r_cfg.repeat_count <= ookpwm_pkg::RST_REPEAT;
        end else if (wr_en) begin
            unique case (reg_idx)
                ookpwm_pkg::REG_SHORT:  r_cfg.short_ticks  <= pwdata[11:0];
                ookpwm_pkg::REG_LONG:   r_cfg.long_ticks   <= pwdata[11:0];
                ookpwm_pkg::REG_GAP:    r_cfg.gap_ticks    <= pwdata[15:0];
                ookpwm_pkg::REG_REPEAT: r_cfg.repeat_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ookpwm_pkg::REG_SHORT:  prdata = {20'd0, r_cfg.short_ticks};
            ookpwm_pkg::REG_LONG:   prdata = {20'd0, r_cfg.long_ticks};
            ookpwm_pkg::REG_GAP:    prdata = {16'd0, r_cfg.gap_ticks};
            ookpwm_pkg::REG_REPEAT: prdata = {28'd0, r_cfg.repeat_count};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

// File: design/ook_pwm_code_transmitter.sv
// ----------------------------------------------------------------------------
// ook_pwm_code_transmitter
// On-off-keyed pulse-width code transmitter, one waveform sample per tick.
// ----------------------------------------------------------------------------
// Input channel: each transaction is a tick (operation 0) or a start (1) that
// carries the code word. A start while idle latches the code; a start while
// busy is dropped and flagged with start_ignored.
// Output channel: exactly one result transaction per input transaction, with
// the data line and power line levels for that tick, busy state after the
// item, and the finished flag on the last tick of the last packet.
// Bits go out MSB first (1 = long high, short low; 0 = short high, long low),
// followed by a trailing 0 bit and a low gap with power on; the packet is
// repeated repeat_count times (a repeat count of zero acts as one).
// Latency: the result is valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle while the receiver is not stalling,
// set by the single state update feeding the result register.
// When the receiver stalls, the result register holds and the input is taken
// only if the result register is empty or being drained in the same cycle.
// Reset (i_rst_n low, synchronous) returns to idle, empties the result
// register and restores the register defaults.
// ----------------------------------------------------------------------------
module ook_pwm_code_transmitter #(
    parameter int CODE_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ookpwm_pkg::t_in                i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ookpwm_pkg::t_out               o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ookpwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int BW = $clog2(CODE_BITS + 1);

    ookpwm_pkg::t_cfg cfg;

    ookpwm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [CODE_BITS-1:0] r_code,    n_code;
    logic [CODE_BITS-1:0] r_shift,   n_shift;
    logic [BW-1:0]        r_bit_idx, n_bit_idx;
    logic [1:0]           r_phase,   n_phase;
    logic [15:0]          r_tick,    n_tick;
    logic [3:0]           r_packets, n_packets;
    logic                 r_active,  n_active;

    logic                 r_out_valid;
    ookpwm_pkg::t_out     r_out,     n_out;

    logic                   accept;
    logic [CODE_BITS+23:0]  code_ext;
    logic                   cur_bit;
    logic [11:0]            hi_len;
    logic [11:0]            lo_len;
    logic [15:0]            raw_len;
    logic [15:0]            phase_len;
    logic [15:0]            tick_inc;
    logic [BW:0]            idx_inc;
    logic [3:0]             pk_dec;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign code_ext = {{CODE_BITS{1'b0}}, i_in_data.code};
    assign cur_bit  = r_shift[CODE_BITS-1];
    assign hi_len   = cur_bit ? cfg.long_ticks : cfg.short_ticks;
    assign lo_len   = cur_bit ? cfg.short_ticks : cfg.long_ticks;
    assign tick_inc = r_tick + 16'd1;
    assign idx_inc  = {1'b0, r_bit_idx} + (BW+1)'(1);
    assign pk_dec   = r_packets - 4'd1;

    always_comb begin
        unique case (r_phase)
            ookpwm_pkg::PH_HIGH: raw_len = {4'd0, hi_len};
            ookpwm_pkg::PH_LOW:  raw_len = {4'd0, lo_len};
            default:             raw_len = cfg.gap_ticks;
        endcase
        phase_len = (raw_len == 16'd0) ? 16'd1 : raw_len;
    end

    always_comb begin
        n_code    = r_code;
        n_shift   = r_shift;
        n_bit_idx = r_bit_idx;
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_packets = r_packets;
        n_active  = r_active;
        n_out     = '0;

        if (i_in_data.operation == ookpwm_pkg::OP_START) begin
            if (r_active) begin
                n_out.start_ignored = 1'b1;
            end else begin
                n_code    = code_ext[CODE_BITS-1:0];
                n_shift   = code_ext[CODE_BITS-1:0];
                n_bit_idx = '0;
                n_phase   = ookpwm_pkg::PH_HIGH;
                n_tick    = 16'd0;
                n_packets = (cfg.repeat_count == 4'd0) ? 4'd1 : cfg.repeat_count;
                n_active  = 1'b1;
            end
        end else if (r_active) begin
            n_out.data_level = (r_phase == ookpwm_pkg::PH_HIGH);
            n_out.tx_power   = 1'b1;
            n_tick           = tick_inc;
            if (tick_inc >= phase_len) begin
                n_tick = 16'd0;
                unique case (r_phase)
                    ookpwm_pkg::PH_HIGH: begin
                        n_phase = ookpwm_pkg::PH_LOW;
                    end
                    ookpwm_pkg::PH_LOW: begin
                        n_bit_idx = idx_inc[BW-1:0];
                        n_shift   = r_shift << 1;
                        n_phase   = (idx_inc <= (BW+1)'(CODE_BITS)) ?
                                    ookpwm_pkg::PH_HIGH : ookpwm_pkg::PH_GAP;
                    end
                    default: begin
                        n_packets = pk_dec;
                        n_bit_idx = '0;
                        n_shift   = r_code;
                        if (pk_dec == 4'd0) begin
                            n_phase          = ookpwm_pkg::PH_IDLE;
                            n_active         = 1'b0;
                            n_out.finished   = 1'b1;
                        end else begin
                            n_phase = ookpwm_pkg::PH_HIGH;
                        end
                    end
                endcase
            end
        end
        n_out.busy_res = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_bit_idx   <= '0;
            r_phase     <= ookpwm_pkg::PH_IDLE;
            r_tick      <= 16'd0;
            r_packets   <= 4'd0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_shift   <= n_shift;
                r_bit_idx <= n_bit_idx;
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_packets <= n_packets;
                r_active  <= n_active;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= n_code;
            r_out  <= n_out;
        end
    end

    a_active_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_phase != ookpwm_pkg::PH_IDLE))
        else $error("active flag disagrees with phase");

    a_packets_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_packets != 4'd0))
        else $error("transmission active with no packets left");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.finished) |-> (!r_out.busy_res && !r_active))
        else $error("finished reported while still busy");

    a_ignored_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.start_ignored) |-> (r_out.busy_res && !r_out.tx_power))
        else $error("start ignored while idle or with power on");

    a_power_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_power) |-> (r_out.busy_res || r_out.finished))
        else $error("power on outside a transmission");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the OOK pulse-width code transmitter. Ticks and
// start commands are pushed through the input channel with random gaps, the
// output channel is stalled at random, and every result is checked against a
// cycle-free waveform predictor kept in a scoreboard. Register settings are
// changed over the APB port between runs, from all-zero to all-ones values.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CODE_BITS   = 24;
    localparam int QUIET_LIMIT = 2000;
    localparam int N_RUNS      = 9;

    class ook_wave_scoreboard;
        logic [11:0]      short_len;
        logic [11:0]      long_len;
        logic [15:0]      gap_len;
        logic [3:0]       rep_count;
        logic [23:0]      code_shift;
        logic [4:0]       bit_idx;
        logic [1:0]       wave_ph;
        logic [15:0]      tick_cnt;
        logic [3:0]       packets_left;
        logic             active;
        ookpwm_pkg::t_out samples_due[$];
        int               n_fail;

        function void reset_state();
            short_len    = ookpwm_pkg::RST_SHORT;
            long_len     = ookpwm_pkg::RST_LONG;
            gap_len      = ookpwm_pkg::RST_GAP;
            rep_count    = ookpwm_pkg::RST_REPEAT;
            code_shift   = '0;
            bit_idx      = '0;
            wave_ph      = ookpwm_pkg::PH_IDLE;
            tick_cnt     = '0;
            packets_left = '0;
            active       = 1'b0;
            n_fail       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                ookpwm_pkg::REG_SHORT:  short_len = val[11:0];
                ookpwm_pkg::REG_LONG:   long_len  = val[11:0];
                ookpwm_pkg::REG_GAP:    gap_len   = val[15:0];
                ookpwm_pkg::REG_REPEAT: rep_count = val[3:0];
                default: ;
            endcase
        endfunction

        function bit is_busy();
            return active;
        endfunction

        function int pending();
            return samples_due.size();
        endfunction

        function logic [15:0] phase_len();
            logic        b;
            logic [15:0] len;
            b = (bit_idx >= CODE_BITS) ? 1'b0 : code_shift[CODE_BITS - 1 - bit_idx];
            if (wave_ph == ookpwm_pkg::PH_HIGH) begin
                len = b ? {4'd0, long_len} : {4'd0, short_len};
            end else if (wave_ph == ookpwm_pkg::PH_LOW) begin
                len = b ? {4'd0, short_len} : {4'd0, long_len};
            end else begin
                len = gap_len;
            end
            return (len == 16'd0) ? 16'd1 : len;
        endfunction

        function void predict_sample(ookpwm_pkg::t_in item);
            ookpwm_pkg::t_out s;
            s = '0;
            if (item.operation == ookpwm_pkg::OP_START) begin
                if (active) begin
                    s.start_ignored = 1'b1;
                end else begin
                    code_shift   = item.code;
                    bit_idx      = '0;
                    wave_ph      = ookpwm_pkg::PH_HIGH;
                    tick_cnt     = '0;
                    packets_left = (rep_count == 4'd0) ? 4'd1 : rep_count;
                    active       = 1'b1;
                end
            end else if (active) begin
                s.data_level = (wave_ph == ookpwm_pkg::PH_HIGH);
                s.tx_power   = 1'b1;
                tick_cnt     = tick_cnt + 16'd1;
                if (tick_cnt >= phase_len()) begin
                    tick_cnt = '0;
                    case (wave_ph)
                        ookpwm_pkg::PH_HIGH: wave_ph = ookpwm_pkg::PH_LOW;
                        ookpwm_pkg::PH_LOW: begin
                            bit_idx = bit_idx + 5'd1;
                            wave_ph = (bit_idx <= CODE_BITS) ?
                                      ookpwm_pkg::PH_HIGH : ookpwm_pkg::PH_GAP;
                        end
                        default: begin
                            packets_left = packets_left - 4'd1;
                            bit_idx      = '0;
                            if (packets_left == 4'd0) begin
                                wave_ph    = ookpwm_pkg::PH_IDLE;
                                active     = 1'b0;
                                s.finished = 1'b1;
                            end else begin
                                wave_ph = ookpwm_pkg::PH_HIGH;
                            end
                        end
                    endcase
                end
            end
            s.busy_res = active;
            samples_due.push_back(s);
        endfunction

        function void cmp_bit(string fname, logic exp_v, logic act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0b, actual %0b",
                         $time, fname, exp_v, act_v);
                n_fail++;
            end
        endfunction

        function void check_sample(ookpwm_pkg::t_out got);
            ookpwm_pkg::t_out exp_s;
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %b",
                         $time, got);
                n_fail++;
                return;
            end
            exp_s = samples_due.pop_front();
            cmp_bit("data_level", exp_s.data_level, got.data_level);
            cmp_bit("tx_power", exp_s.tx_power, got.tx_power);
            cmp_bit("busy_res", exp_s.busy_res, got.busy_res);
            cmp_bit("finished", exp_s.finished, got.finished);
            cmp_bit("start_ignored", exp_s.start_ignored, got.start_ignored);
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    ookpwm_pkg::t_in               i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    ookpwm_pkg::t_out              o_out_data;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [ookpwm_pkg::ADDR_W-1:0] paddr       = '0;
    logic [31:0]                   pwdata      = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    ook_wave_scoreboard sb;
    bit src_idle_on   = 1'b1;
    bit sink_stall_on = 1'b1;
    int quiet_cycles  = 0;

    ook_pwm_code_transmitter #(
        .CODE_BITS(CODE_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output side: random stall bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (sink_stall_on && $urandom_range(0, 11) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_sample(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic op, input logic [23:0] code);
        ookpwm_pkg::t_in item;
        item.operation = op;
        item.code      = code;
        if (src_idle_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.predict_sample(item);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // drains the output channel, then writes all four registers
    task automatic set_config(input logic [11:0] s_len, input logic [11:0] l_len,
                              input logic [15:0] g_len, input logic [3:0] rep);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        apb_write(ookpwm_pkg::REG_SHORT, {20'd0, s_len});
        apb_write(ookpwm_pkg::REG_LONG, {20'd0, l_len});
        apb_write(ookpwm_pkg::REG_GAP, {16'd0, g_len});
        apb_write(ookpwm_pkg::REG_REPEAT, {28'd0, rep});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int n_items, input int start_pct);
        logic        op;
        logic [23:0] code;
        for (int i = 0; i < n_items; i++) begin
            op = ookpwm_pkg::OP_TICK;
            if (sb.is_busy()) begin
                if ($urandom_range(0, 29) == 0) op = ookpwm_pkg::OP_START;
            end else if ($urandom_range(0, 99) < start_pct) begin
                op = ookpwm_pkg::OP_START;
            end
            case ($urandom_range(0, 9))
                0: code = '0;
                1: code = '1;
                default: code = 24'($urandom);
            endcase
            send_item(op, code);
        end
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero lengths and zero repeat count act as one
        set_config(12'd0, 12'd0, 16'd0, 4'd0);
        send_item(ookpwm_pkg::OP_TICK, '1);
        send_item(ookpwm_pkg::OP_TICK, '0);
        send_item(ookpwm_pkg::OP_START, 24'hFFFFFF);
        send_item(ookpwm_pkg::OP_START, '0);
        repeat (16) send_item(ookpwm_pkg::OP_TICK, 24'($urandom));
        send_item(ookpwm_pkg::OP_START, 24'h5A5A5A);

        for (int r = 1; r <= N_RUNS; r++) begin
            if (r == 1) begin
                // all-ones lengths mid-transmission; no fresh start here
                set_config(12'hFFF, 12'hFFF, 16'hFFFF, 4'hF);
                run_random(30, 0);
            end else begin
                if (r == N_RUNS) begin
                    src_idle_on   = 1'b0;
                    sink_stall_on = 1'b0;
                end
                set_config(12'($urandom_range(0, 3)), 12'($urandom_range(0, 6)),
                           16'($urandom_range(0, 24)), 4'($urandom_range(0, 3)));
                run_random(190, 20);
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
